@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked property that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ src/cft_pkg.sv @@
// Types and constants of the CSV field tokenizer.
package cft_pkg;

  // Special bytes
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChNl    = 8'h0A;

  // Input item mode
  typedef enum logic {
    MODE_TEXT = 1'b0,
    MODE_EOI  = 1'b1
  } mode_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_FEND = 2'd1,
    KIND_REND = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_QUOTE_UNQ = 2'd1,
    ERR_JUNK      = 2'd2,
    ERR_NO_CLOSE  = 2'd3
  } err_e;

  // Parser states, one-hot
  typedef enum logic [5:0] {
    ST_REC   = 6'b000001,
    ST_FLD   = 6'b000010,
    ST_UNQ   = 6'b000100,
    ST_QUO   = 6'b001000,
    ST_QSEEN = 6'b010000,
    ST_FAIL  = 6'b100000
  } parse_state_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] char_out;
    err_e       error_code;
  } out_item_t;

endpackage

@@ src/csv_field_tokenizer_unit.sv @@
// CSV field tokenizer: top level with input register, parser and result register.
// Streaming tokenizer for comma-separated records. One byte (or an end-of-input
// mark) is taken per transfer and gives at most one result: a content byte, a
// field end, a field-and-record end, or an error with its code. Quoted fields
// keep commas and newlines as data and turn a doubled quote into one quote;
// after an error the parser drops bytes until end of input. Throughput is one
// item per cycle while results are taken. The input register takes the item on
// its transfer and the result register takes its result when the result slot
// is free or being emptied. A stalled result holds back the input register,
// and through it in_ready_o. The next-state decision on one byte between those
// two registers is the whole datapath.
module csv_field_tokenizer_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cft_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cft_pkg::out_item_t  out_data_o
);
  import cft_pkg::*;

  logic         in_valid_q;
  in_item_t     in_q;
  logic         out_valid_q, out_valid_d;
  out_item_t    out_q;
  parse_state_e state_q, state_d;
  logic         advance;
  logic         emit;
  out_item_t    res;
  logic         is_nl, is_comma, is_quote;

  // Input stage moves on when the result slot is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  assign is_nl    = (in_q.char_in == ChNl);
  assign is_comma = (in_q.char_in == ChComma);
  assign is_quote = (in_q.char_in == ChQuote);

  // Next state and result for the registered item
  always_comb begin
    state_d = state_q;
    emit    = 1'b0;
    res     = '{kind: KIND_DATA, char_out: '0, error_code: ERR_NONE};
    if (in_q.mode == MODE_EOI) begin
      state_d = ST_REC;
      unique case (state_q)
        ST_FLD, ST_UNQ, ST_QSEEN: begin
          emit     = 1'b1;
          res.kind = KIND_REND;
        end
        ST_QUO: begin
          emit           = 1'b1;
          res.kind       = KIND_ERR;
          res.error_code = ERR_NO_CLOSE;
        end
        default: ;
      endcase
    end else begin
      unique case (state_q)
        ST_REC, ST_FLD: begin
          if (is_nl) begin
            // blank line at record start is skipped
            if (state_q == ST_FLD) begin
              state_d  = ST_REC;
              emit     = 1'b1;
              res.kind = KIND_REND;
            end
          end else if (is_comma) begin
            state_d  = ST_FLD;
            emit     = 1'b1;
            res.kind = KIND_FEND;
          end else if (is_quote) begin
            state_d = ST_QUO;
          end else begin
            state_d      = ST_UNQ;
            emit         = 1'b1;
            res.char_out = in_q.char_in;
          end
        end
        ST_UNQ: begin
          emit = 1'b1;
          if (is_nl) begin
            state_d  = ST_REC;
            res.kind = KIND_REND;
          end else if (is_comma) begin
            state_d  = ST_FLD;
            res.kind = KIND_FEND;
          end else if (is_quote) begin
            state_d        = ST_FAIL;
            res.kind       = KIND_ERR;
            res.error_code = ERR_QUOTE_UNQ;
          end else begin
            res.char_out = in_q.char_in;
          end
        end
        ST_QUO: begin
          if (is_quote) begin
            state_d = ST_QSEEN;
          end else begin
            emit         = 1'b1;
            res.char_out = in_q.char_in;
          end
        end
        ST_QSEEN: begin
          emit = 1'b1;
          if (is_quote) begin
            // escaped quote
            state_d      = ST_QUO;
            res.char_out = in_q.char_in;
          end else if (is_comma) begin
            state_d  = ST_FLD;
            res.kind = KIND_FEND;
          end else if (is_nl) begin
            state_d  = ST_REC;
            res.kind = KIND_REND;
          end else begin
            state_d        = ST_FAIL;
            res.kind       = KIND_ERR;
            res.error_code = ERR_JUNK;
          end
        end
        default: state_d = ST_FAIL;
      endcase
    end
  end

  // Result slot: loaded on advance, held while stalled
  always_comb begin
    if (advance) begin
      out_valid_d = emit;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_REC;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/cft_checker.sv @@
// Port-level checker for the CSV field tokenizer, bound to the top level.
`include "assert_macros.svh"

module cft_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input cft_pkg::in_item_t   in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cft_pkg::out_item_t  out_data_o
);
  import cft_pkg::*;

  // A stalled result stays put
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // Only error results carry a code, and every error carries one
  `ASSERT_CLK(a_code_only_err, clk_i, rst_ni, out_valid_o && out_data_o.kind != KIND_ERR |-> out_data_o.error_code == ERR_NONE)
  `ASSERT_CLK(a_err_has_code, clk_i, rst_ni, out_valid_o && out_data_o.kind == KIND_ERR |-> out_data_o.error_code != ERR_NONE)

  // Marks and errors carry no byte
  `ASSERT_CLK(a_mark_no_byte, clk_i, rst_ni, out_valid_o && out_data_o.kind != KIND_DATA |-> out_data_o.char_out == 8'h00)

  // Nothing is offered while in reset
  `ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o)

endmodule

bind csv_field_tokenizer_unit cft_checker u_cft_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the CSV field tokenizer top level.
`timescale 1ns / 1ps

module testbench;
  import cft_pkg::*;

  // Tokenizer state as tracked by the predictor
  typedef enum logic [2:0] {
    PS_REC,
    PS_AFTER_COMMA,
    PS_BARE,
    PS_QUOTED,
    PS_QUOTE_PEND,
    PS_FAILED
  } tok_state_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  tok_state_e tok_state = PS_REC;
  out_item_t  token_q[$];
  int         mismatch_count = 0;
  int         live_items = 0;
  int         src_idle_pct = 37;
  int         dst_idle_pct = 56;

  csv_field_tokenizer_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= dst_idle_pct);
  end

  function automatic out_item_t make_token(kind_e k, logic [7:0] c, err_e e);
    out_item_t t;
    t.kind       = k;
    t.char_out   = c;
    t.error_code = e;
    return t;
  endfunction

  // Next-state decision on one item; updates tok_state
  function automatic void predict_token(input in_item_t item, output bit has_tok,
                                        output out_item_t tok);
    tok_state_e cur;
    logic [7:0] c;
    cur     = tok_state;
    c       = item.char_in;
    has_tok = 1'b0;
    tok     = make_token(KIND_DATA, 8'h00, ERR_NONE);
    if (item.mode == MODE_EOI) begin
      tok_state = PS_REC;
      if (cur == PS_AFTER_COMMA || cur == PS_BARE || cur == PS_QUOTE_PEND) begin
        has_tok = 1'b1;
        tok     = make_token(KIND_REND, 8'h00, ERR_NONE);
      end else if (cur == PS_QUOTED) begin
        has_tok = 1'b1;
        tok     = make_token(KIND_ERR, 8'h00, ERR_NO_CLOSE);
      end
    end else begin
      case (cur)
        PS_REC, PS_AFTER_COMMA: begin
          if (c == ChNl) begin
            // blank line at record start is skipped
            if (cur == PS_AFTER_COMMA) begin
              tok_state = PS_REC;
              has_tok   = 1'b1;
              tok       = make_token(KIND_REND, 8'h00, ERR_NONE);
            end
          end else if (c == ChComma) begin
            tok_state = PS_AFTER_COMMA;
            has_tok   = 1'b1;
            tok       = make_token(KIND_FEND, 8'h00, ERR_NONE);
          end else if (c == ChQuote) begin
            tok_state = PS_QUOTED;
          end else begin
            tok_state = PS_BARE;
            has_tok   = 1'b1;
            tok       = make_token(KIND_DATA, c, ERR_NONE);
          end
        end
        PS_BARE: begin
          has_tok = 1'b1;
          if (c == ChNl) begin
            tok_state = PS_REC;
            tok       = make_token(KIND_REND, 8'h00, ERR_NONE);
          end else if (c == ChComma) begin
            tok_state = PS_AFTER_COMMA;
            tok       = make_token(KIND_FEND, 8'h00, ERR_NONE);
          end else if (c == ChQuote) begin
            tok_state = PS_FAILED;
            tok       = make_token(KIND_ERR, 8'h00, ERR_QUOTE_UNQ);
          end else begin
            tok = make_token(KIND_DATA, c, ERR_NONE);
          end
        end
        PS_QUOTED: begin
          if (c == ChQuote) begin
            tok_state = PS_QUOTE_PEND;
          end else begin
            has_tok = 1'b1;
            tok     = make_token(KIND_DATA, c, ERR_NONE);
          end
        end
        PS_QUOTE_PEND: begin
          has_tok = 1'b1;
          if (c == ChQuote) begin
            // doubled quote is one literal quote
            tok_state = PS_QUOTED;
            tok       = make_token(KIND_DATA, c, ERR_NONE);
          end else if (c == ChComma) begin
            tok_state = PS_AFTER_COMMA;
            tok       = make_token(KIND_FEND, 8'h00, ERR_NONE);
          end else if (c == ChNl) begin
            tok_state = PS_REC;
            tok       = make_token(KIND_REND, 8'h00, ERR_NONE);
          end else begin
            tok_state = PS_FAILED;
            tok       = make_token(KIND_ERR, 8'h00, ERR_JUNK);
          end
        end
        default: begin
          // failed: text bytes dropped until end of input
          tok_state = PS_FAILED;
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Result checker
  always @(posedge clk) begin : token_check
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (token_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_data));
      end else begin
        want = token_q.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
        if (out_data.char_out !== want.char_out)
          report_mismatch($sformatf("char_out %02h, want %02h",
                                    out_data.char_out, want.char_out));
        if (out_data.error_code !== want.error_code)
          report_mismatch($sformatf("error_code %0d, want %0d",
                                    out_data.error_code, want.error_code));
      end
    end
  end

  // Send one item; entered and left at a falling edge
  task automatic send_item(input in_item_t item);
    int        gap;
    bit        has_tok;
    out_item_t tok;
    if ($urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (tok_state != PS_FAILED)
      live_items++;
    predict_token(item, has_tok, tok);
    if (has_tok)
      token_q.insert(token_q.size(), tok);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] c);
    in_item_t item;
    item.mode    = MODE_TEXT;
    item.char_in = c;
    send_item(item);
  endtask

  task automatic send_eoi();
    in_item_t item;
    item.mode    = MODE_EOI;
    item.char_in = 8'($urandom_range(255));
    send_item(item);
  endtask

  // Hold the sender off until every expected result has come
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] bare_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == ChComma || b == ChQuote || b == ChNl);
    return b;
  endfunction

  // Content byte for a quoted field, heavy on separators
  function automatic logic [7:0] quoted_byte();
    case ($urandom_range(9))
      0: return ChComma;
      1: return ChNl;
      2: return ChQuote;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(7))
      0: return ChComma;
      1: return ChNl;
      2, 3: return ChQuote;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Well-formed record with random fields
  task automatic send_random_record();
    int         n_fields;
    int         len;
    logic [7:0] b;
    n_fields = $urandom_range(1, 4);
    if ($urandom_range(9) == 0)
      send_byte(ChNl);
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0)
        send_byte(ChComma);
      len = $urandom_range(0, 5);
      case ($urandom_range(4))
        0: ;
        1, 2: repeat (len) send_byte(bare_byte());
        default: begin
          send_byte(ChQuote);
          repeat (len) begin
            b = quoted_byte();
            send_byte(b);
            if (b == ChQuote)
              send_byte(ChQuote);
          end
          send_byte(ChQuote);
        end
      endcase
    end
    if ($urandom_range(9) == 0)
      send_eoi();
    else
      send_byte(ChNl);
  endtask

  // Raw bytes and broken records
  task automatic send_noise();
    int len;
    len = $urandom_range(1, 6);
    case ($urandom_range(3))
      0: repeat (len) begin
        if ($urandom_range(7) == 0)
          send_eoi();
        else
          send_byte(noise_byte());
      end
      1: begin
        // stray quote inside a bare field
        send_byte(bare_byte());
        send_byte(ChQuote);
        repeat (len) send_byte(noise_byte());
      end
      2: begin
        // junk after a closing quote
        send_byte(ChQuote);
        repeat (len) send_byte(bare_byte());
        send_byte(ChQuote);
        send_byte(bare_byte());
      end
      default: begin
        // quoted field that may be cut short by end of input
        send_byte(ChQuote);
        repeat (len) send_byte(quoted_byte() == ChQuote ? 8'h41 : quoted_byte());
      end
    endcase
    if ($urandom_range(3) != 0)
      send_eoi();
  endtask

  // Record boundaries, blank lines, empty fields, byte extremes
  task automatic test_record_shapes();
    send_eoi();          // end of input at record start
    send_byte(ChNl);     // blank line skipped
    send_byte(ChComma);  // empty first field
    send_byte(ChNl);     // empty last field closes record
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0D);    // carriage return is plain data
    send_eoi();          // end of input in a bare field
  endtask

  // Quoted fields: doubled quotes, separators as data
  task automatic test_quoting();
    send_byte(ChQuote);
    send_byte(ChQuote);  // quote right after the opening one closes
    send_byte(ChQuote);  // and another makes it a literal quote
    send_byte(ChQuote);
    send_byte(ChComma);
    send_eoi();          // end of input after a comma
    send_byte(ChQuote);
    send_byte(ChComma);
    send_byte(ChNl);
    send_byte(ChQuote);
    send_eoi();          // end of input after a closing quote
  endtask

  // Every error and the failed state
  task automatic test_errors();
    send_byte(ChQuote);
    send_eoi();          // missing closing quote
    send_byte(8'h61);
    send_byte(ChQuote);  // quote inside a bare field
    send_byte(8'hFF);    // dropped while failed
    send_eoi();          // end of input while failed
    send_byte(ChQuote);
    send_byte(8'h71);
    send_byte(ChQuote);
    send_byte(8'h00);    // junk after closing quote
    send_eoi();
    wait_for_results();
  endtask

  task automatic test_random_stream(input int src_pct, input int dst_pct, input int n_items);
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    live_items   = 0;
    while (live_items < n_items) begin
      if ($urandom_range(9) < 8)
        send_random_record();
      else
        send_noise();
      if ($urandom_range(49) == 0)
        wait_for_results();
    end
    wait_for_results();
  endtask

  // Run-time limit
  initial begin
    #1_000_000;
    $display("csv_field_tokenizer_unit regression: fail");
    $finish;
  end

  initial begin
    // falling reset edge once every process waits on it
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_record_shapes();
    test_quoting();
    test_errors();
    test_random_stream(37, 56, 650);
    test_random_stream(56, 37, 650);
    test_random_stream(0, 0, 650);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && token_q.size() == 0) begin
      $display("csv_field_tokenizer_unit regression: pass");
    end else begin
      $display("csv_field_tokenizer_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/cft_pkg.sv
src/csv_field_tokenizer_unit.sv
src/cft_checker.sv
tb/sv/testbench.sv
